// ----- sv/iqed_pkg.sv -----
// Shared types and constants for the I/Q energy packet detector.
`default_nettype none
package iqed_pkg;

  localparam int unsigned MAG_W   = 12;   // magnitude, 3 fractional bits, max 2884
  localparam int unsigned ROOT_W  = 23;   // 64 * (di^2 + dq^2)
  localparam int unsigned ACC_W   = 19;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned IDX_W   = 32;
  localparam int unsigned OPA_W   = 82;   // widest multiplicand (sum of two 80-bit products)
  localparam int unsigned OPB_W   = 32;
  localparam int unsigned PROD_W  = OPA_W + OPB_W;

  localparam logic [ACC_W-1:0] ACC_MAX   = '1;
  localparam logic [SUM_W-1:0] SUM_MAX   = '1;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic [1:0] CFG_RATIO   = 2'd0;
  localparam logic [1:0] CFG_LEVEL   = 2'd1;
  localparam logic [1:0] CFG_HOLDOFF = 2'd2;

  localparam logic [3:0]  RATIO_RST   = 4'd3;
  localparam logic [6:0]  LEVEL_RST   = 7'd70;
  localparam logic [19:0] HOLDOFF_RST = 20'd28672;

  typedef struct packed {
    logic [3:0]  ratio;
    logic [6:0]  level;
    logic [19:0] holdoff;
  } cfg_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_ROOT,
    FR_DONE
  } fr_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_RUN,
    BK_DECIDE
  } bk_state_t;

endpackage
`default_nettype wire

// ----- sv/iqed_front.sv -----
// Front end: magnitude by bitwise square root and window accumulation.
`default_nettype none
module iqed_front #(
  parameter int unsigned WINDOW_SIZE = 128,
  parameter int unsigned FW = $clog2(WINDOW_SIZE + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [7:0]                   i_sample,
  input  wire logic [7:0]                   q_sample,
  input  wire logic                         chunk_end,
  output      logic                         push,
  input  wire logic                         full,
  output      logic [iqed_pkg::IDX_W-1:0]   push_start,
  output      logic [FW-1:0]                push_wn,
  output      logic [iqed_pkg::ACC_W-1:0]   push_sum
);
  import iqed_pkg::*;

  fr_state_t          state, state_next;
  logic [ROOT_W-1:0]  rad;
  logic [MAG_W-1:0]   root;
  logic [3:0]         bitn;
  logic               close_req;
  logic [ACC_W-1:0]   acc;
  logic [FW-1:0]      fill;
  logic [IDX_W-1:0]   scount;

  logic [7:0]         ai, aq;
  logic [16:0]        energy;
  logic [MAG_W-1:0]   trial;
  logic [23:0]        trial_sq;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_new;
  logic [FW-1:0]      fill_new;
  logic [IDX_W-1:0]   scount_new;
  logic               closing;
  logic               finish;

  // Distance from 127.5 doubled: |2x - 255| is always odd and fits 8 bits.
  assign ai = i_sample[7] ? 8'({i_sample[6:0], 1'b1}) : 8'(~{i_sample[6:0], 1'b0});
  assign aq = q_sample[7] ? 8'({q_sample[6:0], 1'b1}) : 8'(~{q_sample[6:0], 1'b0});
  assign energy = 17'(16'(ai) * 16'(ai)) + 17'(16'(aq) * 16'(aq));

  assign trial    = root | (MAG_W'(1) << bitn);
  assign trial_sq = 24'(trial) * 24'(trial);

  assign acc_sum    = {1'b0, acc} + (ACC_W + 1)'(root);
  assign acc_new    = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
  assign fill_new   = fill + FW'(1);
  assign scount_new = scount + IDX_W'(1);
  assign closing    = close_req || (fill_new >= FW'(WINDOW_SIZE));

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (in_valid) state_next = FR_ROOT;
      FR_ROOT: if (bitn == 4'd0) state_next = FR_DONE;
      FR_DONE: if (!closing || !full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != FR_IDLE);
    finish   = (state == FR_DONE) && (!closing || !full);
    push     = finish && closing;
  end

  assign push_start = scount_new - IDX_W'(fill_new);
  assign push_wn    = fill_new;
  assign push_sum   = acc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FR_IDLE;
      acc    <= '0;
      fill   <= '0;
      scount <= '0;
    end else begin
      state <= state_next;
      if (finish) begin
        scount <= scount_new;
        acc    <= closing ? '0 : acc_new;
        fill   <= closing ? '0 : fill_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && in_valid) begin
      rad       <= {energy, 6'b0};
      root      <= '0;
      bitn      <= 4'(MAG_W - 1);
      close_req <= chunk_end;
    end else if (state == FR_ROOT) begin
      if ({1'b0, rad} >= trial_sq) root <= trial;
      bitn <= bitn - 4'd1;
    end
  end

endmodule
`default_nettype wire

// ----- sv/iqed_fifo.sv -----
// Two-entry queue of closed windows between the front and back ends.
`default_nettype none
module iqed_fifo #(
  parameter int unsigned WIDTH = 59
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             not_empty
);
  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// ----- sv/iqed_back.sv -----
// Back end: noise and signal statistics, exact ratio tests, result register.
`default_nettype none
module iqed_back #(
  parameter int unsigned FW = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire iqed_pkg::cfg_t             cfg,
  input  wire logic                       rec_valid,
  output      logic                       rec_pop,
  input  wire logic [iqed_pkg::IDX_W-1:0] rec_start,
  input  wire logic [FW-1:0]              rec_wn,
  input  wire logic [iqed_pkg::ACC_W-1:0] rec_sum,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic                       detected,
  output      logic [31:0]                start_index,
  output      logic [7:0]                 window_samples,
  output      logic [18:0]                window_sum,
  output      logic                       in_signal
);
  import iqed_pkg::*;

  localparam logic [2:0] PH_FIRST     = 3'd0;
  localparam logic [2:0] PH_LAST_SEED = 3'd1;
  localparam logic [2:0] PH_SUM_NC    = 3'd2;
  localparam logic [2:0] PH_SUM_SC    = 3'd3;
  localparam logic [2:0] PH_LAST_TRK  = 3'd4;

  bk_state_t          state, state_next;
  logic [2:0]         phase;
  logic [SUM_W-1:0]   noise_sum, signal_sum;
  logic [CNT_W-1:0]   noise_count, signal_count;
  logic [IDX_W-1:0]   last_detect;
  logic               latch, noise_seen, signal_seen;
  logic [IDX_W-1:0]   r_start;
  logic [FW-1:0]      r_wn;
  logic [ACC_W-1:0]   r_sum;
  logic [PROD_W-1:0]  mcand, prod, lhs, rhs;
  logic [OPB_W-1:0]   mplier;
  logic [OPA_W-1:0]   tmp;

  logic [OPA_W-1:0]   op_a;
  logic [OPB_W-1:0]   op_b;
  logic [25:0]        sum100;
  logic [OPB_W-1:0]   k_ratio, k_level;
  logic               last_phase;
  logic               out_free, load_out;
  logic               gt, hold_ok;
  logic [IDX_W-1:0]   holdoff_gap;
  logic [SUM_W:0]     ns_add, ss_add;
  logic [CNT_W:0]     nc_add, sc_add;
  logic [SUM_W-1:0]   ns_sat, ss_sat;
  logic [CNT_W-1:0]   nc_sat, sc_sat;
  logic               det_next, latch_next;

  assign sum100  = 26'(r_sum) * 26'd100;
  assign k_ratio = 32'(cfg.ratio) * 32'(r_wn);
  assign k_level = 32'(cfg.level) * 32'(r_wn);

  // Operand selection for the shared shift-add multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (!signal_seen) begin
      case (phase)
        PH_FIRST:     begin op_a = OPA_W'(r_sum);      op_b = noise_count; end
        PH_LAST_SEED: begin op_a = OPA_W'(noise_sum);  op_b = k_ratio;     end
        default:      begin op_a = '0;                 op_b = '0;          end
      endcase
    end else begin
      case (phase)
        PH_FIRST:     begin op_a = OPA_W'(sum100);     op_b = noise_count;  end
        PH_LAST_SEED: begin op_a = tmp;                op_b = signal_count; end
        PH_SUM_NC:    begin op_a = OPA_W'(noise_sum);  op_b = signal_count; end
        PH_SUM_SC:    begin op_a = OPA_W'(signal_sum); op_b = noise_count;  end
        PH_LAST_TRK:  begin op_a = tmp;                op_b = k_level;      end
        default:      begin op_a = '0;                 op_b = '0;           end
      endcase
    end
  end

  assign last_phase = signal_seen ? (phase == PH_LAST_TRK) : (phase == PH_LAST_SEED);
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (rec_valid) state_next = noise_seen ? BK_SETUP : BK_DECIDE;
      BK_SETUP:  state_next = BK_RUN;
      BK_RUN:    if (mplier == '0) state_next = last_phase ? BK_DECIDE : BK_SETUP;
      BK_DECIDE: if (out_free) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    rec_pop  = (state == BK_IDLE) && rec_valid;
    load_out = (state == BK_DECIDE) && out_free;
  end

  // Decision on a closed window.
  assign gt          = lhs > rhs;
  assign holdoff_gap = r_start - last_detect;
  assign hold_ok     = holdoff_gap > IDX_W'(cfg.holdoff);
  assign ns_add  = {1'b0, noise_sum} + (SUM_W + 1)'(r_sum);
  assign ss_add  = {1'b0, signal_sum} + (SUM_W + 1)'(r_sum);
  assign nc_add  = {1'b0, noise_count} + (CNT_W + 1)'(r_wn);
  assign sc_add  = {1'b0, signal_count} + (CNT_W + 1)'(r_wn);
  assign ns_sat  = ns_add[SUM_W] ? SUM_MAX : ns_add[SUM_W-1:0];
  assign ss_sat  = ss_add[SUM_W] ? SUM_MAX : ss_add[SUM_W-1:0];
  assign nc_sat  = nc_add[CNT_W] ? CNT_MAX : nc_add[CNT_W-1:0];
  assign sc_sat  = sc_add[CNT_W] ? CNT_MAX : sc_add[CNT_W-1:0];

  always_comb begin
    det_next   = 1'b0;
    latch_next = latch;
    if (!noise_seen) begin
      latch_next = 1'b0;
    end else if (!signal_seen) begin
      if (gt) begin
        det_next   = 1'b1;
        latch_next = 1'b1;
      end
    end else if (gt) begin
      if (!latch && hold_ok) begin
        det_next   = 1'b1;
        latch_next = 1'b1;
      end
    end else if (hold_ok) begin
      latch_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      noise_sum    <= '0;
      noise_count  <= '0;
      signal_sum   <= '0;
      signal_count <= '0;
      last_detect  <= '0;
      latch        <= 1'b0;
      noise_seen   <= 1'b0;
      signal_seen  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
        latch     <= latch_next;
        if (det_next) last_detect <= r_start;
        if (!noise_seen) begin
          noise_sum   <= SUM_W'(r_sum);
          noise_count <= CNT_W'(r_wn);
          noise_seen  <= 1'b1;
        end else if (!signal_seen && gt) begin
          signal_sum   <= SUM_W'(r_sum);
          signal_count <= CNT_W'(r_wn);
          signal_seen  <= 1'b1;
        end else if (signal_seen && gt) begin
          signal_sum   <= ss_sat;
          signal_count <= sc_sat;
        end else begin
          noise_sum   <= ns_sat;
          noise_count <= nc_sat;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      r_start <= rec_start;
      r_wn    <= rec_wn;
      r_sum   <= rec_sum;
      phase   <= PH_FIRST;
    end
    if (state == BK_SETUP) begin
      mcand  <= PROD_W'(op_a);
      mplier <= op_b;
      prod   <= '0;
    end else if (state == BK_RUN) begin
      if (mplier != '0) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end else begin
        phase <= phase + 3'd1;
        if (!signal_seen) begin
          if (phase == PH_FIRST) lhs <= prod;
          else rhs <= prod;
        end else begin
          case (phase)
            PH_FIRST:     tmp <= prod[OPA_W-1:0];
            PH_LAST_SEED: lhs <= prod;
            PH_SUM_NC:    tmp <= prod[OPA_W-1:0];
            PH_SUM_SC:    tmp <= tmp + prod[OPA_W-1:0];
            default:      rhs <= prod;
          endcase
        end
      end
    end
    if (load_out) begin
      detected       <= det_next;
      start_index    <= r_start;
      window_samples <= (32'(r_wn) > 32'd255) ? 8'd255 : 8'(r_wn);
      window_sum     <= r_sum;
      in_signal      <= latch_next;
    end
  end

`ifndef ASSERT_OFF
  a_det_latched: assert property (@(posedge clk) disable iff (rst)
    out_valid && detected |-> in_signal)
    else $error("detection reported without the latch set");

  a_signal_after_noise: assert property (@(posedge clk) disable iff (rst)
    signal_seen |-> noise_seen)
    else $error("signal statistics started before noise statistics");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    rec_pop |=> (state == BK_SETUP || state == BK_DECIDE))
    else $error("window taken from queue but no evaluation started");
`endif

endmodule
`default_nettype wire

// ----- sv/iq_energy_packet_detector.sv -----
// Top level of the I/Q energy packet detector: config registers, front, queue, back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   in      | in        | in_valid/in_stall  | i_sample, q_sample, chunk_end
//   out     | out       | out_valid/out_stall| detected, start_index, window_samples,
//           |           |                    | window_sum, in_signal
//   cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// In the front end each sample is accepted, then taken through the bitwise
// square root of the magnitude, and then accumulated into the window.
// Each closed window then passes through the back end, whose shift-add
// multiplier retires one multiplier bit per cycle over no product for the
// first window, two before the first signal and five after it.
// A two-entry queue of closed windows sits between the front and back ends.
// Reset is synchronous and returns statistics, configuration and control state to defaults.
// A stalled output holds its result; the front end stalls when the queue is full.
`default_nettype none
module iq_energy_packet_detector #(
  parameter int unsigned WINDOW_SIZE = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  i_sample,
  input  wire logic [7:0]  q_sample,
  input  wire logic        chunk_end,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        detected,
  output      logic [31:0] start_index,
  output      logic [7:0]  window_samples,
  output      logic [18:0] window_sum,
  output      logic        in_signal,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);
  import iqed_pkg::*;

  localparam int unsigned FW    = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned REC_W = IDX_W + FW + ACC_W;

  cfg_t              cfg;
  logic              push, full, pop, not_empty;
  logic [IDX_W-1:0]  push_start;
  logic [FW-1:0]     push_wn;
  logic [ACC_W-1:0]  push_sum;
  logic [REC_W-1:0]  pop_data;

  // Configuration writes are always taken; an index past the list is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio   <= RATIO_RST;
      cfg.level   <= LEVEL_RST;
      cfg.holdoff <= HOLDOFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RATIO:   cfg.ratio   <= cfg_data[3:0];
        CFG_LEVEL:   cfg.level   <= cfg_data[6:0];
        CFG_HOLDOFF: cfg.holdoff <= cfg_data;
        default:     ;
      endcase
    end
  end

  // The front end computes magnitudes and closes windows.
  iqed_front #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .FW          (FW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .i_sample   (i_sample),
    .q_sample   (q_sample),
    .chunk_end  (chunk_end),
    .push       (push),
    .full       (full),
    .push_start (push_start),
    .push_wn    (push_wn),
    .push_sum   (push_sum)
  );

  // Closed windows wait here so either side can stall independently.
  iqed_fifo #(
    .WIDTH (REC_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_start, push_wn, push_sum}),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  // The back end updates noise and signal means and decides on detection.
  iqed_back #(
    .FW (FW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .rec_valid      (not_empty),
    .rec_pop        (pop),
    .rec_start      (pop_data[REC_W-1 -: IDX_W]),
    .rec_wn         (pop_data[ACC_W +: FW]),
    .rec_sum        (pop_data[ACC_W-1:0]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .detected       (detected),
    .start_index    (start_index),
    .window_samples (window_samples),
    .window_sum     (window_sum),
    .in_signal      (in_signal)
  );

endmodule
`default_nettype wire

// ----- tb/iqed_checker.sv -----
// Checker for the I/Q energy packet detector: predicts window results and compares them.
module iqed_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  i_sample,
  input  wire logic [7:0]  q_sample,
  input  wire logic        chunk_end,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        detected,
  input  wire logic [31:0] start_index,
  input  wire logic [7:0]  window_samples,
  input  wire logic [18:0] window_sum,
  input  wire logic        in_signal,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  output int               fails,
  output int               pending
);
  import iqed_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN = 128;

  typedef struct {
    logic        detected;
    logic [31:0] start;
    logic [7:0]  samples;
    logic [18:0] sum;
    logic        latch;
  } window_report_t;

  window_report_t reports_due[$];

  cfg_t        cfg;
  logic [31:0] sample_cnt;
  logic [18:0] win_acc;
  logic [7:0]  win_fill;
  logic [47:0] noise_sum, signal_sum;
  logic [31:0] noise_cnt, signal_cnt;
  logic [31:0] last_detect;
  logic        latch, noise_seen, signal_seen;

  function automatic logic [11:0] magnitude(logic [7:0] i, logic [7:0] q);
    int          di, dq;
    logic [31:0] v, res, b;
    di = 2 * int'(i) - 255;
    dq = 2 * int'(q) - 255;
    v = 32'(di * di + dq * dq) * 32'd64;
    res = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[11:0];
  endfunction

  function automatic logic [47:0] add48_sat(logic [47:0] a, logic [18:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? SUM_MAX : s[47:0];
  endfunction

  function automatic logic [31:0] add32_sat(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? CNT_MAX : s[31:0];
  endfunction

  task automatic take_sample(logic [7:0] i, logic [7:0] q, logic ce);
    logic [19:0]    acc_next;
    logic [18:0]    wsum;
    logic [7:0]     wn;
    logic [31:0]    start, gap;
    logic [63:0]    scaled;
    logic [127:0]   lhs, rhs, both;
    window_report_t r;
    r.detected = 1'b0;
    sample_cnt = sample_cnt + 1;
    acc_next = 20'(win_acc) + 20'(magnitude(i, q));
    win_acc = acc_next[19] ? ACC_MAX : acc_next[18:0];
    win_fill = win_fill + 1;
    if (win_fill < WIN && !ce) return;
    wsum = win_acc;
    wn = win_fill;
    start = sample_cnt - 32'(wn);
    if (!signal_seen) begin
      if (!noise_seen) begin
        noise_sum = 48'(wsum);
        noise_cnt = 32'(wn);
        noise_seen = 1'b1;
        latch = 1'b0;
      end else begin
        lhs = 128'(wsum) * 128'(noise_cnt);
        rhs = 128'(noise_sum) * (128'(cfg.ratio) * 128'(wn));
        if (lhs > rhs) begin
          signal_sum = 48'(wsum);
          signal_cnt = 32'(wn);
          signal_seen = 1'b1;
          last_detect = start;
          latch = 1'b1;
          r.detected = 1'b1;
        end else begin
          noise_sum = add48_sat(noise_sum, wsum);
          noise_cnt = add32_sat(noise_cnt, wn);
        end
      end
    end else begin
      scaled = 64'd100 * 64'(wsum) * 64'(noise_cnt);
      lhs = 128'(scaled) * 128'(signal_cnt);
      both = 128'(noise_sum) * 128'(signal_cnt) + 128'(signal_sum) * 128'(noise_cnt);
      rhs = both * (128'(cfg.level) * 128'(wn));
      gap = start - last_detect;
      if (lhs > rhs) begin
        signal_sum = add48_sat(signal_sum, wsum);
        signal_cnt = add32_sat(signal_cnt, wn);
        if (!latch && gap > 32'(cfg.holdoff)) begin
          last_detect = start;
          latch = 1'b1;
          r.detected = 1'b1;
        end
      end else begin
        noise_sum = add48_sat(noise_sum, wsum);
        noise_cnt = add32_sat(noise_cnt, wn);
        if (gap > 32'(cfg.holdoff)) latch = 1'b0;
      end
    end
    r.start = start;
    r.samples = wn;
    r.sum = wsum;
    r.latch = latch;
    reports_due.push_back(r);
    win_acc = 0;
    win_fill = 0;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    window_report_t w;
    if (rst) begin
      cfg <= '{ratio: RATIO_RST, level: LEVEL_RST, holdoff: HOLDOFF_RST};
      sample_cnt = 0; win_acc = 0; win_fill = 0;
      noise_sum = 0; noise_cnt = 0; signal_sum = 0; signal_cnt = 0;
      last_detect = 0; latch = 0; noise_seen = 0; signal_seen = 0;
      reports_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          fails++;
          $display("%0t: result with none expected, actual start %0h sum %0h",
                   $time, start_index, window_sum);
        end else begin
          w = reports_due.pop_front();
          compare_field("detected", 32'(w.detected), 32'(detected));
          compare_field("start_index", w.start, start_index);
          compare_field("window_samples", 32'(w.samples), 32'(window_samples));
          compare_field("window_sum", 32'(w.sum), 32'(window_sum));
          compare_field("in_signal", 32'(w.latch), 32'(in_signal));
        end
      end
      if (in_valid && !in_stall) take_sample(i_sample, q_sample, chunk_end);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RATIO:   cfg.ratio <= cfg_data[3:0];
          CFG_LEVEL:   cfg.level <= cfg_data[6:0];
          CFG_HOLDOFF: cfg.holdoff <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= reports_due.size();
  end

  initial begin
    fails = 0;
    pending = 0;
  end
endmodule

// ----- tb/tb_iq_energy_packet_detector.sv -----
// Testbench top for the I/Q energy packet detector: stimulus, stalls and verdict.
module tb_iq_energy_packet_detector;
  import iqed_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted request before the run is declared hung.
  localparam int HANG_LIMIT = 20000;
  // Drain time once nothing is expected: covers a sample in the front end
  // and the back end's longest multiply.
  localparam int DRAIN_CYCLES = 300;
  localparam int TOTAL_ITEMS = 1100;
  // An index past the register list; writes to it are ignored.
  localparam logic [1:0] CFG_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  i_sample = '0;
  logic [7:0]  q_sample = '0;
  logic        chunk_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        detected;
  logic [31:0] start_index;
  logic [7:0]  window_samples;
  logic [18:0] window_sum;
  logic        in_signal;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  int          fails;
  int          pending;

  int          samples_sent = 0;
  bit          calm = 1'b0;     // no idling on either side once set
  int          idle_cycles = 0;
  int          stall_burst = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  iq_energy_packet_detector dut (
    .clk, .rst, .in_valid, .in_stall, .i_sample, .q_sample, .chunk_end,
    .out_valid, .out_stall, .detected, .start_index, .window_samples,
    .window_sum, .in_signal, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  iqed_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .i_sample, .q_sample, .chunk_end,
    .out_valid, .out_stall, .detected, .start_index, .window_samples,
    .window_sum, .in_signal, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fails, .pending
  );

  // The result side stalls in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_burst = 0;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      stall_burst = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any accepted request on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || rst)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one sample request, sometimes after a gap, and holds it until taken.
  task automatic send_sample(logic [7:0] i, logic [7:0] q, logic ce);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    i_sample <= i;
    q_sample <= q;
    chunk_end <= ce;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    samples_sent++;
    if (samples_sent > TOTAL_ITEMS - 150) calm = 1'b1;
  endtask

  // Waits until every expected result has come and the back end has drained.
  // Registers are only written after this.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
  endtask

  // One window: quiet samples sit near the center, loud ones far from it.
  // Most windows are short and closed by chunk_end; a few run to full size.
  task automatic send_window(bit loud);
    int          len;
    bit          full;
    logic [7:0]  i, q;
    full = ($urandom_range(0, 19) == 0);
    len = full ? 128 : $urandom_range(1, 12);
    for (int k = 0; k < len; k++) begin
      if (loud) begin
        i = $urandom_range(0, 3) == 0 ? 8'($urandom)
          : ($urandom_range(0, 1) ? 8'($urandom_range(0, 20))
                                  : 8'($urandom_range(235, 255)));
        q = 8'($urandom);
      end else begin
        i = 8'($urandom_range(120, 135));
        q = 8'($urandom_range(120, 135));
      end
      send_sample(i, q, (k == len - 1) && !full);
    end
  endtask

  initial begin
    logic [19:0] hold;
    int          n_windows;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: closest-to-center and extreme samples, a one-sample
    // window seeding the noise mean, then an extreme window for the first
    // signal, and out-of-range and unknown writes.
    write_reg(CFG_RATIO, 20'd15);
    write_reg(CFG_LEVEL, 20'd100);
    write_reg(CFG_HOLDOFF, 20'd0);
    write_reg(CFG_UNKNOWN, 20'hFFFFF);
    send_sample(8'd127, 8'd128, 1'b1);
    send_sample(8'd128, 8'd127, 1'b0);
    send_sample(8'd127, 8'd127, 1'b1);
    settle();
    write_reg(CFG_RATIO, 20'd0);
    send_sample(8'd0, 8'd0, 1'b0);
    send_sample(8'd255, 8'd255, 1'b1);
    send_sample(8'd0, 8'd255, 1'b1);
    send_sample(8'd128, 8'd128, 1'b1);
    send_sample(8'd255, 8'd0, 1'b1);
    settle();
    write_reg(CFG_LEVEL, 20'd127);
    write_reg(CFG_HOLDOFF, 20'hFFFFF);
    send_sample(8'd170, 8'd85, 1'b1);
    send_sample(8'd85, 8'd170, 1'b1);
    for (int k = 0; k < 12; k++) send_sample(8'(k * 21), 8'(255 - k * 21), k == 11);

    // Random part: each phase has its own settings, then a run of quiet and
    // loud windows with a little noise mixed in.
    while (samples_sent < TOTAL_ITEMS) begin
      settle();
      case ($urandom_range(0, 3))
        0: hold = 20'd0;
        1: hold = 20'($urandom_range(1, 400));
        2: hold = 20'hFFFFF;
        default: hold = 20'($urandom);
      endcase
      write_reg(CFG_RATIO, 20'($urandom_range(0, 15)));
      write_reg(CFG_LEVEL, $urandom_range(0, 3) == 0 ? 20'($urandom_range(101, 127))
                                                      : 20'($urandom_range(1, 100)));
      write_reg(CFG_HOLDOFF, hold);
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNKNOWN, 20'($urandom));
      n_windows = $urandom_range(6, 16);
      for (int w = 0; w < n_windows && samples_sent < TOTAL_ITEMS; w++) begin
        if ($urandom_range(0, 9) == 0)
          send_sample(8'($urandom), 8'($urandom), 1'($urandom));
        else
          send_window($urandom_range(0, 9) < 4);
      end
    end

    settle();
    if (fails == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
